FILE: sv/tle_pkg.sv
// Package for the terminal line editor: character codes, command classes,
// result kinds and the back-end state encoding. No dependencies.
package tle_pkg;

    localparam int TLE_LINE_CAPACITY = 32;
    localparam int TLE_CMD_DEPTH     = 4;

    localparam logic [7:0] TLE_CH_LF    = 8'd10;
    localparam logic [7:0] TLE_CH_CR    = 8'd13;
    localparam logic [7:0] TLE_CH_BS    = 8'd8;
    localparam logic [7:0] TLE_CH_DEL   = 8'd127;
    localparam logic [7:0] TLE_CH_SPACE = 8'd32;

    typedef enum logic [1:0] {
        TLE_CLS_CHAR  = 2'd0,
        TLE_CLS_EOL   = 2'd1,
        TLE_CLS_ERASE = 2'd2
    } tle_cls_t;

    typedef enum logic [1:0] {
        TLE_KIND_ECHO = 2'd0,
        TLE_KIND_LINE = 2'd1,
        TLE_KIND_END  = 2'd2
    } tle_kind_t;

    typedef struct packed {
        tle_cls_t   cls;
        logic [7:0] rx_byte;
    } tle_cmd_t;

    typedef enum logic [2:0] {
        TLE_BK_IDLE,
        TLE_BK_CHAR,
        TLE_BK_LF,
        TLE_BK_CR,
        TLE_BK_LINE,
        TLE_BK_BS1,
        TLE_BK_SPACE,
        TLE_BK_BS2
    } tle_back_state_t;

endpackage

FILE: sv/tle_front.sv
// Front end of the terminal line editor: accepts received bytes and tags
// each one with its command class. Depends on tle_pkg.
module tle_front
    import tle_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // rx_byte[7:0]
    input  logic       queue_full,
    output logic       push,
    output tle_cmd_t   cmd
);

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        cmd.rx_byte = s_tdata;
        if (s_tdata inside {TLE_CH_CR, TLE_CH_LF}) begin
            cmd.cls = TLE_CLS_EOL;
        end else if (s_tdata inside {TLE_CH_BS, TLE_CH_DEL}) begin
            cmd.cls = TLE_CLS_ERASE;
        end else begin
            cmd.cls = TLE_CLS_CHAR;
        end
    end

endmodule

FILE: sv/tle_cmd_fifo.sv
// Short command queue between the front and back ends of the line editor.
// Depends on tle_pkg for the command type.
module tle_cmd_fifo
    import tle_pkg::*;
#(
    parameter int DEPTH = TLE_CMD_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  tle_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output tle_cmd_t pop_data,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tle_cmd_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/tle_back.sv
// Back end of the line editor: owns the line store and fill count, carries
// out queued commands and drives the registered result stream. Uses tle_pkg.
module tle_back
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = TLE_LINE_CAPACITY
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  tle_cmd_t   cmd,
    output logic       cmd_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // data[7:0]
    output logic [1:0] m_tuser,     // kind[1:0]
    output logic       m_tlast      // last
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int CW = $clog2(LINE_CAPACITY + 1);

    tle_back_state_t state_reg, state_next;
    logic [CW-1:0]   fill_reg,  fill_next;
    logic [CW-1:0]   idx_reg,   idx_next;
    logic [7:0]      byte_reg,  byte_next;
    logic [7:0]      line_mem [LINE_CAPACITY];
    logic [7:0]      rd_data_reg;
    logic            wr_en;

    logic            out_valid_reg;
    tle_kind_t       out_kind_reg;
    logic [7:0]      out_data_reg;
    logic            out_last_reg;

    logic            out_free;
    logic            emit;
    tle_kind_t       emit_kind;
    logic [7:0]      emit_data;
    logic            emit_last;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        emit       = 1'b0;
        emit_kind  = TLE_KIND_ECHO;
        emit_data  = byte_reg;
        emit_last  = 1'b0;
        case (state_reg)
            TLE_BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop   = 1'b1;
                    byte_next = cmd.rx_byte;
                    idx_next  = '0;
                    // A full store completes the line whatever the byte is.
                    if (cmd.cls == TLE_CLS_EOL || fill_reg >= CW'(LINE_CAPACITY)) begin
                        state_next = TLE_BK_LF;
                    end else if (cmd.cls == TLE_CLS_ERASE) begin
                        if (fill_reg != '0) begin
                            fill_next  = fill_reg - 1'b1;
                            state_next = TLE_BK_BS1;
                        end
                    end else begin
                        wr_en      = 1'b1;
                        fill_next  = fill_reg + 1'b1;
                        state_next = TLE_BK_CHAR;
                    end
                end
            end
            TLE_BK_CHAR: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (out_free) state_next = TLE_BK_IDLE;
            end
            TLE_BK_LF: begin
                emit      = 1'b1;
                emit_data = TLE_CH_LF;
                if (out_free) state_next = TLE_BK_CR;
            end
            TLE_BK_CR: begin
                emit      = 1'b1;
                emit_data = TLE_CH_CR;
                if (out_free) state_next = TLE_BK_LINE;
            end
            TLE_BK_LINE: begin
                emit = 1'b1;
                if (idx_reg != fill_reg) begin
                    emit_kind = TLE_KIND_LINE;
                    emit_data = rd_data_reg;
                    if (out_free) idx_next = idx_reg + 1'b1;
                end else begin
                    emit_kind = TLE_KIND_END;
                    emit_data = '0;
                    emit_last = 1'b1;
                    if (out_free) begin
                        fill_next  = '0;
                        state_next = TLE_BK_IDLE;
                    end
                end
            end
            TLE_BK_BS1: begin
                emit      = 1'b1;
                emit_data = TLE_CH_BS;
                if (out_free) state_next = TLE_BK_SPACE;
            end
            TLE_BK_SPACE: begin
                emit      = 1'b1;
                emit_data = TLE_CH_SPACE;
                if (out_free) state_next = TLE_BK_BS2;
            end
            TLE_BK_BS2: begin
                emit      = 1'b1;
                emit_data = TLE_CH_BS;
                emit_last = 1'b1;
                if (out_free) state_next = TLE_BK_IDLE;
            end
            default: begin
                state_next = TLE_BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= TLE_BK_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            if (emit && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        if (emit && out_free) begin
            out_kind_reg <= emit_kind;
            out_data_reg <= emit_data;
            out_last_reg <= emit_last;
        end
    end

    // Line store: the read address follows the next line index, so the
    // registered read data always matches the current index.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[fill_reg[AW-1:0]] <= cmd.rx_byte;
        end
        rd_data_reg <= line_mem[idx_next[AW-1:0]];
    end

endmodule

FILE: sv/terminal_line_editor_unit.sv
// Terminal line editor with echo: top level joining front end, command queue and back end.
// An accepted byte passes the command queue and the back-end state before its first result.
// An echo gives one result, an erase BS, space, BS (none on an empty line), a line end LF,
// CR, the line bytes and an end marker; at most one result a cycle while m_tready is high.
// Reset (aresetn, synchronous, active low) empties the queue, clears the fill count and the
// output valid; the line store is not cleared, as only written entries are ever read.
module terminal_line_editor_unit
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = TLE_LINE_CAPACITY,
    parameter int CMD_DEPTH     = TLE_CMD_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // rx_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // data[7:0]
    output logic [1:0] m_tuser,     // kind[1:0]
    output logic       m_tlast      // last
);

    // The front end tags each received byte as a plain character, a line end
    // or an erase, and drops it into the queue; it only stalls when the queue is full.
    logic     queue_full;
    logic     queue_empty;
    logic     push;
    logic     pop;
    tle_cmd_t push_cmd;
    tle_cmd_t pop_cmd;

    tle_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    tle_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (queue_empty)
    );

    // The back end holds the line store and fill count. It decides at command
    // time whether a full store turns the byte into a line completion, then
    // streams the echo, line bytes and end marker through its output register.
    tle_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!queue_empty),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The end marker always closes the results of its byte and carries zero data.
    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == TLE_KIND_END) |-> (m_tlast && m_tdata == 8'd0))
        else $error("line end marker without last or with nonzero data");

    // A line byte is always followed by more results of the same completion.
    a_line_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == TLE_KIND_LINE) |-> !m_tlast)
        else $error("line byte marked as last result");

    // Once a line byte is taken, the next result is another line byte or the marker.
    a_line_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser == TLE_KIND_LINE) |=>
            (!m_tvalid || m_tuser == TLE_KIND_LINE || m_tuser == TLE_KIND_END))
        else $error("line bytes interrupted by an echo");

endmodule
